[design/fec_pkg.sv]
// Types and constants shared by the free extent coalescer files.
package fec_pkg;

    localparam int FIELD_W = 48;
    localparam int COUNT_W = 7;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_IN_PRED   = 3'd1,
        ST_OVER_SUCC = 3'd2,
        ST_FULL      = 3'd3,
        ST_ADDR_OVF  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_PLACE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
    } t_entry;

    typedef struct packed {
        logic [FIELD_W-1:0] region_start;
        logic [FIELD_W-1:0] region_length;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         status;
        logic [FIELD_W-1:0] merged_start;
        logic [FIELD_W-1:0] merged_length;
        logic [FIELD_W-1:0] free_total;
        logic [COUNT_W-1:0] extent_count;
    } t_out_beat;

endpackage

[design/fec_if.sv]
// Valid/ready channel interfaces for freed extents and results.
interface fec_in_if;
    logic                valid;
    logic                ready;
    fec_pkg::t_in_beat   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fec_out_if;
    logic                valid;
    logic                ready;
    fec_pkg::t_out_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/fec_mem.sv]
// Extent table memory: one write port, one read port, registered read data.
module fec_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  fec_pkg::t_entry   i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output fec_pkg::t_entry   o_rdata
);
    fec_pkg::t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/free_extent_coalescer_core.sv]
// Free extent coalescer: sorted free-extent table in memory with merge on free.
// One beat in, one beat out. An item scans the table from entry 0 one entry per
// cycle until it passes its start address or reaches the end of the table (no
// scan on an empty table), takes a decision step, then shifts the tail of the
// table one entry per cycle when an extent is inserted or two extents join, then
// places an inserted extent, and then a result step places the result, waiting
// while an earlier result is still not taken. The table memory has one write port
// and one read port. Zero-length and address-overflow items skip the scan and go
// straight to the result step. No clearing pass after reset.
module free_extent_coalescer_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_BITS   = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fec_in_if.sink     i_in,
    fec_out_if.source  o_out
);
    localparam int FW = fec_pkg::FIELD_W;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam bit OVF_CHECK = (ADDR_BITS < FW + 1);

    fec_pkg::t_state  r_state, n_state;
    logic [FW-1:0]    r_s, n_s, r_len, n_len;
    logic [FW:0]      r_end, n_end;
    logic [CW-1:0]    r_idx, n_idx, r_n, n_n, r_cnt, n_cnt;
    logic [AW-1:0]    r_rp, n_rp, r_wp, n_wp;
    logic             r_up, n_up;
    fec_pkg::t_entry  r_pred, n_pred, r_succ, n_succ;
    logic             r_has_pred, n_has_pred, r_has_succ, n_has_succ;
    fec_pkg::t_status r_status, n_status;
    logic [FW-1:0]    r_ms, n_ms, r_ml, n_ml, r_total, n_total;
    logic             r_ov, n_ov;
    fec_pkg::t_out_beat r_out, n_out;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    fec_pkg::t_entry  mem_wdata, mem_rdata;

    logic [FW:0]      in_end, pred_end, s_ext;
    logic             in_ovf, join_p, join_s;

    fec_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_in.ready  = (r_state == fec_pkg::S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    assign in_end   = {1'b0, i_in.data.region_start} + {1'b0, i_in.data.region_length};
    assign in_ovf   = OVF_CHECK && ((in_end >> ADDR_BITS) != '0);
    assign pred_end = {1'b0, r_pred.start} + {1'b0, r_pred.len};
    assign s_ext    = {1'b0, r_s};
    assign join_p   = r_has_pred && (pred_end == s_ext);
    assign join_s   = r_has_succ && ({1'b0, r_succ.start} == r_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fec_pkg::S_IDLE;
            r_n     <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_total <= n_total;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s        <= n_s;
        r_len      <= n_len;
        r_end      <= n_end;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_rp       <= n_rp;
        r_wp       <= n_wp;
        r_up       <= n_up;
        r_pred     <= n_pred;
        r_succ     <= n_succ;
        r_has_pred <= n_has_pred;
        r_has_succ <= n_has_succ;
        r_status   <= n_status;
        r_ms       <= n_ms;
        r_ml       <= n_ml;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_s        = r_s;
        n_len      = r_len;
        n_end      = r_end;
        n_idx      = r_idx;
        n_n        = r_n;
        n_cnt      = r_cnt;
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_up       = r_up;
        n_pred     = r_pred;
        n_succ     = r_succ;
        n_has_pred = r_has_pred;
        n_has_succ = r_has_succ;
        n_status   = r_status;
        n_ms       = r_ms;
        n_ml       = r_ml;
        n_total    = r_total;
        n_out      = r_out;
        n_ov       = r_ov && !o_out.ready;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;

        unique case (r_state)
            fec_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_s        = i_in.data.region_start;
                    n_len      = i_in.data.region_length;
                    n_end      = in_end;
                    n_idx      = '0;
                    n_has_pred = 1'b0;
                    n_has_succ = 1'b0;
                    n_status   = fec_pkg::ST_OK;
                    n_ms       = '0;
                    n_ml       = '0;
                    if (i_in.data.region_length == '0) begin
                        n_ms    = i_in.data.region_start;
                        n_state = fec_pkg::S_RESULT;
                    end else if (in_ovf) begin
                        n_status = fec_pkg::ST_ADDR_OVF;
                        n_state  = fec_pkg::S_RESULT;
                    end else if (r_n == '0) begin
                        n_state = fec_pkg::S_DECIDE;
                    end else begin
                        mem_raddr = '0;
                        n_state   = fec_pkg::S_SCAN;
                    end
                end
            end
            fec_pkg::S_SCAN: begin
                if (mem_rdata.start <= r_s) begin
                    n_pred     = mem_rdata;
                    n_has_pred = 1'b1;
                    n_idx      = CW'(r_idx + 1'b1);
                    if (CW'(r_idx + 1'b1) < r_n) begin
                        mem_raddr = AW'(r_idx + 1'b1);
                    end else begin
                        n_state = fec_pkg::S_DECIDE;
                    end
                end else begin
                    n_succ     = mem_rdata;
                    n_has_succ = 1'b1;
                    n_state    = fec_pkg::S_DECIDE;
                end
            end
            fec_pkg::S_DECIDE: begin
                n_state = fec_pkg::S_RESULT;
                if (r_has_pred && (s_ext < pred_end)) begin
                    n_status = fec_pkg::ST_IN_PRED;
                end else if (r_has_succ && (r_end > {1'b0, r_succ.start})) begin
                    n_status = fec_pkg::ST_OVER_SUCC;
                end else if (!join_p && !join_s && (r_n >= CW'(TABLE_DEPTH))) begin
                    n_status = fec_pkg::ST_FULL;
                end else begin
                    n_total = r_total + r_len;
                    if (join_p && join_s) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(r_idx - 1'b1);
                        mem_wdata = '{start: r_pred.start,
                                      len: r_pred.len + r_len + r_succ.len};
                        n_ms      = mem_wdata.start;
                        n_ml      = mem_wdata.len;
                        n_n       = r_n - 1'b1;
                        n_cnt     = r_n - 1'b1 - r_idx;
                        n_up      = 1'b0;
                        mem_raddr = AW'(r_idx + 1'b1);
                        n_rp      = AW'(r_idx + 2'd2);
                        n_wp      = AW'(r_idx);
                        if (n_cnt != '0) begin
                            n_state = fec_pkg::S_SHIFT;
                        end
                    end else if (join_p) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(r_idx - 1'b1);
                        mem_wdata = '{start: r_pred.start, len: r_pred.len + r_len};
                        n_ms      = mem_wdata.start;
                        n_ml      = mem_wdata.len;
                    end else if (join_s) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(r_idx);
                        mem_wdata = '{start: r_s, len: r_succ.len + r_len};
                        n_ms      = r_s;
                        n_ml      = mem_wdata.len;
                    end else begin
                        n_ms      = r_s;
                        n_ml      = r_len;
                        n_n       = r_n + 1'b1;
                        n_cnt     = r_n - r_idx;
                        n_up      = 1'b1;
                        mem_raddr = AW'(r_n - 1'b1);
                        n_rp      = AW'(r_n - 2'd2);
                        n_wp      = AW'(r_n);
                        n_state   = (n_cnt != '0) ? fec_pkg::S_SHIFT : fec_pkg::S_PLACE;
                    end
                end
            end
            fec_pkg::S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_wp;
                mem_wdata = mem_rdata;
                n_cnt     = r_cnt - 1'b1;
                n_wp      = r_up ? AW'(r_wp - 1'b1) : AW'(r_wp + 1'b1);
                if (r_cnt > CW'(1)) begin
                    mem_raddr = r_rp;
                    n_rp      = r_up ? AW'(r_rp - 1'b1) : AW'(r_rp + 1'b1);
                end else begin
                    n_state = r_up ? fec_pkg::S_PLACE : fec_pkg::S_RESULT;
                end
            end
            fec_pkg::S_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_idx);
                mem_wdata = '{start: r_s, len: r_len};
                n_state   = fec_pkg::S_RESULT;
            end
            fec_pkg::S_RESULT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov  = 1'b1;
                    n_out = '{status: r_status, merged_start: r_ms, merged_length: r_ml,
                              free_total: r_total,
                              extent_count: fec_pkg::COUNT_W'(r_n)};
                    n_state = fec_pkg::S_IDLE;
                end
            end
            default: n_state = fec_pkg::S_IDLE;
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(TABLE_DEPTH))
        else $error("extent count above table depth");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != fec_pkg::S_IDLE))
        else $error("accepted beat did not start work");

    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fec_pkg::S_SHIFT) |-> (r_cnt != '0))
        else $error("shift with no entries left");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fec_pkg::S_DECIDE && r_has_pred && (s_ext < pred_end))
        |=> (r_n == $past(r_n) && r_total == $past(r_total)))
        else $error("rejected free changed table state");
endmodule
